FILE: rtl/tft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tft_pkg;

   localparam int CNT_BITS = 32;
   localparam int THR_BITS = 16;
   localparam int OUTCOME_BITS = 3;
   localparam logic [THR_BITS-1:0] THR_RESET = 16'd2;
   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

   localparam logic [OUTCOME_BITS-1:0] OC_MAIN_HIT = 3'd0;
   localparam logic [OUTCOME_BITS-1:0] OC_CAND_HIT = 3'd1;
   localparam logic [OUTCOME_BITS-1:0] OC_PROMOTE_FREE = 3'd2;
   localparam logic [OUTCOME_BITS-1:0] OC_PROMOTE_SWAP = 3'd3;
   localparam logic [OUTCOME_BITS-1:0] OC_QUALIFIED = 3'd4;
   localparam logic [OUTCOME_BITS-1:0] OC_NEW = 3'd5;
   localparam logic [OUTCOME_BITS-1:0] OC_NEW_EVICT = 3'd6;
   localparam logic [OUTCOME_BITS-1:0] OC_KEY_ZERO = 3'd7;

   typedef struct packed {
      logic load;
      logic decide;
      logic [OUTCOME_BITS-1:0] outcome;
      logic main_inc;
      logic cand_inc;
      logic promote;
      logic swap;
      logic ins_new;
      logic ins_dem;
      logic main_bub;
      logic cand_bub;
   } cmd_type;

   typedef struct packed {
      logic key_zero;
      logic main_hit;
      logic cand_hit;
      logic below_thr;
      logic main_full;
      logic last_le;
      logic cand_full;
      logic mswap_any;
      logic cswap_any;
   } status_type;

   function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/tft_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tft_req_if #(parameter int KEY_BITS = 32);
   logic valid;
   logic ready;
   logic [KEY_BITS-1:0] key;
   modport source (output valid, output key, input ready);
   modport sink (input valid, input key, output ready);
endinterface
`default_nettype wire

FILE: rtl/tft_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tft_rsp_if #(parameter int MAIN_DEPTH = 16, parameter int CAND_DEPTH = 32);
   logic valid;
   logic ready;
   logic [tft_pkg::OUTCOME_BITS-1:0] outcome;
   logic [tft_pkg::CNT_BITS-1:0] key_count;
   logic [$clog2(MAIN_DEPTH+1)-1:0] main_used;
   logic [$clog2(CAND_DEPTH+1)-1:0] candidates_used;
   logic [tft_pkg::CNT_BITS-1:0] removal_total;
   modport source (output valid, output outcome, output key_count, output main_used,
                   output candidates_used, output removal_total, input ready);
   modport sink (input valid, input outcome, input key_count, input main_used,
                 input candidates_used, input removal_total, output ready);
endinterface
`default_nettype wire

FILE: rtl/tft_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tft_csr_if;
   logic valid;
   logic ready;
   logic [tft_pkg::THR_BITS-1:0] promote_threshold;
   modport source (output valid, output promote_threshold, input ready);
   modport sink (input valid, input promote_threshold, output ready);
endinterface
`default_nettype wire

FILE: rtl/tft_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tft_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire tft_pkg::status_type status,
   output tft_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_INS_NEW = 3'd2;
   localparam logic [2:0] S_INS_DEM = 3'd3;
   localparam logic [2:0] S_MBUB = 3'd4;
   localparam logic [2:0] S_CBUB = 3'd5;
   localparam logic [2:0] S_RESP = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.decide = 1'b1;
            priority if (status.key_zero) begin
               cmd.outcome = tft_pkg::OC_KEY_ZERO;
               state_in = S_RESP;
            end else if (status.main_hit) begin
               cmd.outcome = tft_pkg::OC_MAIN_HIT;
               cmd.main_inc = 1'b1;
               state_in = S_MBUB;
            end else if (status.cand_hit && status.below_thr) begin
               cmd.outcome = tft_pkg::OC_CAND_HIT;
               cmd.cand_inc = 1'b1;
               state_in = S_CBUB;
            end else if (status.cand_hit && !status.main_full) begin
               cmd.outcome = tft_pkg::OC_PROMOTE_FREE;
               cmd.promote = 1'b1;
               state_in = S_MBUB;
            end else if (status.cand_hit && status.last_le) begin
               cmd.outcome = tft_pkg::OC_PROMOTE_SWAP;
               cmd.swap = 1'b1;
               state_in = S_INS_DEM;
            end else if (status.cand_hit) begin
               cmd.outcome = tft_pkg::OC_QUALIFIED;
               cmd.cand_inc = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.outcome = status.cand_full ? tft_pkg::OC_NEW_EVICT : tft_pkg::OC_NEW;
               state_in = S_INS_NEW;
            end
         end
         S_INS_NEW: begin
            cmd.ins_new = 1'b1;
            state_in = S_RESP;
         end
         S_INS_DEM: begin
            cmd.ins_dem = 1'b1;
            state_in = S_MBUB;
         end
         S_MBUB: begin
            cmd.main_bub = 1'b1;
            if (!status.mswap_any) begin
               state_in = S_RESP;
            end
         end
         S_CBUB: begin
            cmd.cand_bub = 1'b1;
            if (!status.cswap_any) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_SEARCH)
      else $error("accepted word did not start a search");

   a_resp_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !rsp_ready) |=> state_ff == S_RESP)
      else $error("result dropped before it was taken");

   a_one_side_open: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input open while a result waits");

endmodule
`default_nettype wire

FILE: rtl/tft_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tft_datapath #(
   parameter int MAIN_DEPTH = 16,
   parameter int CAND_DEPTH = 32,
   parameter int KEY_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [KEY_BITS-1:0] req_key,
   input  wire logic csr_valid,
   input  wire logic [tft_pkg::THR_BITS-1:0] csr_data,
   input  wire tft_pkg::cmd_type cmd,
   output tft_pkg::status_type status,
   output logic [tft_pkg::OUTCOME_BITS-1:0] outcome,
   output logic [tft_pkg::CNT_BITS-1:0] key_count,
   output logic [$clog2(MAIN_DEPTH+1)-1:0] main_used,
   output logic [$clog2(CAND_DEPTH+1)-1:0] candidates_used,
   output logic [tft_pkg::CNT_BITS-1:0] removal_total
);

   localparam int CB = tft_pkg::CNT_BITS;
   localparam int MFW = $clog2(MAIN_DEPTH+1);
   localparam int CFW = $clog2(CAND_DEPTH+1);
   localparam int MIW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
   localparam int CIW = $clog2(CAND_DEPTH);
   localparam logic [MIW-1:0] MLAST = MIW'(MAIN_DEPTH-1);
   localparam logic [CIW-1:0] CLAST = CIW'(CAND_DEPTH-1);

   logic [KEY_BITS-1:0] mkey_ff [MAIN_DEPTH];
   logic [KEY_BITS-1:0] mkey_in [MAIN_DEPTH];
   logic [CB-1:0] mcnt_ff [MAIN_DEPTH];
   logic [CB-1:0] mcnt_in [MAIN_DEPTH];
   logic [KEY_BITS-1:0] ckey_ff [CAND_DEPTH];
   logic [KEY_BITS-1:0] ckey_in [CAND_DEPTH];
   logic [CB-1:0] ccnt_ff [CAND_DEPTH];
   logic [CB-1:0] ccnt_in [CAND_DEPTH];
   logic [MFW-1:0] mfill_ff, mfill_in;
   logic [CFW-1:0] cfill_ff, cfill_in;
   logic [MIW-1:0] mpos_ff, mpos_in;
   logic [CIW-1:0] cpos_ff, cpos_in;
   logic [CB-1:0] removals_ff, removals_in;
   logic [tft_pkg::THR_BITS-1:0] thr_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] dk_ff;
   logic [CB-1:0] dc_ff;
   logic [CB-1:0] kc_ff;
   logic [tft_pkg::OUTCOME_BITS-1:0] outcome_ff;

   logic [MAIN_DEPTH-1:0] mhit_vec, mswap_vec;
   logic [CAND_DEPTH-1:0] chit_vec, cswap_vec;
   logic [MIW-1:0] midx;
   logic [CIW-1:0] cidx;
   logic [CB-1:0] msel_cnt, csel_cnt, kc_new;
   logic [KEY_BITS-1:0] ins_key;
   logic [CB-1:0] ins_cnt;
   logic [CIW-1:0] ins_pos, ins_lim;
   logic ins_found, cand_full;

   // search over both lists
   always_comb begin
      midx = '0;
      msel_cnt = '0;
      for (int j = 0; j < MAIN_DEPTH; j++) begin
         mhit_vec[j] = (MFW'(j) < mfill_ff) && (mkey_ff[j] == key_ff);
         if (mhit_vec[j]) begin
            midx = midx | MIW'(j);
            msel_cnt = msel_cnt | mcnt_ff[j];
         end
      end
      cidx = '0;
      csel_cnt = '0;
      for (int j = 0; j < CAND_DEPTH; j++) begin
         chit_vec[j] = (CFW'(j) < cfill_ff) && (ckey_ff[j] == key_ff);
         if (chit_vec[j]) begin
            cidx = cidx | CIW'(j);
            csel_cnt = csel_cnt | ccnt_ff[j];
         end
      end
      priority if (key_ff == '0) begin
         kc_new = '0;
      end else if (|mhit_vec) begin
         kc_new = tft_pkg::sat_inc(msel_cnt);
      end else if (|chit_vec) begin
         kc_new = tft_pkg::sat_inc(csel_cnt);
      end else begin
         kc_new = CB'(1);
      end
   end

   // one bubble step per cycle
   always_comb begin
      mswap_vec = '0;
      for (int j = 1; j < MAIN_DEPTH; j++) begin
         mswap_vec[j] = (mpos_ff == MIW'(j)) && (mcnt_ff[j] > mcnt_ff[j-1]);
      end
      cswap_vec = '0;
      for (int j = 1; j < CAND_DEPTH; j++) begin
         cswap_vec[j] = (cpos_ff == CIW'(j)) && (ccnt_ff[j] > ccnt_ff[j-1]);
      end
   end

   // sorted insert position
   assign cand_full = (cfill_ff == CFW'(CAND_DEPTH));
   assign ins_key = cmd.ins_dem ? dk_ff : key_ff;
   assign ins_cnt = cmd.ins_dem ? dc_ff : CB'(1);

   always_comb begin
      ins_found = 1'b0;
      ins_pos = '0;
      for (int j = CAND_DEPTH - 1; j >= 0; j--) begin
         if ((CFW'(j) < cfill_ff) && (ccnt_ff[j] <= ins_cnt)) begin
            ins_found = 1'b1;
            ins_pos = CIW'(j);
         end
      end
      ins_lim = cand_full ? CLAST : CIW'(cfill_ff);
      if (!ins_found) begin
         ins_pos = ins_lim;
      end
   end

   always_comb begin
      status.key_zero = (key_ff == '0);
      status.main_hit = |mhit_vec;
      status.cand_hit = |chit_vec;
      status.below_thr = kc_new < {{(CB-tft_pkg::THR_BITS){1'b0}}, thr_ff};
      status.main_full = (mfill_ff == MFW'(MAIN_DEPTH));
      status.last_le = (mcnt_ff[MAIN_DEPTH-1] <= kc_new);
      status.cand_full = cand_full;
      status.mswap_any = |mswap_vec;
      status.cswap_any = |cswap_vec;
   end

   // main table next state
   always_comb begin
      mkey_in = mkey_ff;
      mcnt_in = mcnt_ff;
      mfill_in = mfill_ff;
      mpos_in = mpos_ff;
      if (cmd.main_inc) begin
         for (int j = 0; j < MAIN_DEPTH; j++) begin
            if (mhit_vec[j]) begin
               mcnt_in[j] = tft_pkg::sat_inc(mcnt_ff[j]);
            end
         end
         mpos_in = midx;
      end else if (cmd.promote) begin
         for (int j = 0; j < MAIN_DEPTH; j++) begin
            if (MFW'(j) == mfill_ff) begin
               mkey_in[j] = key_ff;
               mcnt_in[j] = kc_new;
            end
         end
         mfill_in = mfill_ff + 1'b1;
         mpos_in = MIW'(mfill_ff);
      end else if (cmd.swap) begin
         mkey_in[MAIN_DEPTH-1] = key_ff;
         mcnt_in[MAIN_DEPTH-1] = kc_new;
         mpos_in = MLAST;
      end else if (cmd.main_bub && (|mswap_vec)) begin
         for (int j = 1; j < MAIN_DEPTH; j++) begin
            if (mswap_vec[j]) begin
               mkey_in[j] = mkey_ff[j-1];
               mcnt_in[j] = mcnt_ff[j-1];
               mkey_in[j-1] = mkey_ff[j];
               mcnt_in[j-1] = mcnt_ff[j];
            end
         end
         mpos_in = mpos_ff - 1'b1;
      end
   end

   // candidate list next state
   always_comb begin
      ckey_in = ckey_ff;
      ccnt_in = ccnt_ff;
      cfill_in = cfill_ff;
      cpos_in = cpos_ff;
      if (cmd.cand_inc) begin
         for (int j = 0; j < CAND_DEPTH; j++) begin
            if (chit_vec[j]) begin
               ccnt_in[j] = tft_pkg::sat_inc(ccnt_ff[j]);
            end
         end
         cpos_in = cidx;
      end else if (cmd.promote || cmd.swap) begin
         for (int j = 0; j < CAND_DEPTH; j++) begin
            if (CFW'(j + 1) == cfill_ff) begin
               ckey_in[j] = '0;
               ccnt_in[j] = '0;
            end else if (j < CAND_DEPTH - 1) begin
               if ((CIW'(j) >= cidx) && (CFW'(j + 1) < cfill_ff)) begin
                  ckey_in[j] = ckey_ff[j+1];
                  ccnt_in[j] = ccnt_ff[j+1];
               end
            end
         end
         cfill_in = cfill_ff - 1'b1;
      end else if (cmd.ins_new || cmd.ins_dem) begin
         for (int j = 0; j < CAND_DEPTH; j++) begin
            if (CIW'(j) == ins_pos) begin
               ckey_in[j] = ins_key;
               ccnt_in[j] = ins_cnt;
            end else if (j > 0) begin
               if ((CIW'(j) > ins_pos) && (CIW'(j) <= ins_lim)) begin
                  ckey_in[j] = ckey_ff[j-1];
                  ccnt_in[j] = ccnt_ff[j-1];
               end
            end
         end
         if (!cand_full) begin
            cfill_in = cfill_ff + 1'b1;
         end
      end else if (cmd.cand_bub && (|cswap_vec)) begin
         for (int j = 1; j < CAND_DEPTH; j++) begin
            if (cswap_vec[j]) begin
               ckey_in[j] = ckey_ff[j-1];
               ccnt_in[j] = ccnt_ff[j-1];
               ckey_in[j-1] = ckey_ff[j];
               ccnt_in[j-1] = ccnt_ff[j];
            end
         end
         cpos_in = cpos_ff - 1'b1;
      end
   end

   assign removals_in = (cmd.promote || cmd.swap) ? tft_pkg::sat_inc(removals_ff) : removals_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAIN_DEPTH; j++) begin
            mkey_ff[j] <= '0;
            mcnt_ff[j] <= '0;
         end
         for (int j = 0; j < CAND_DEPTH; j++) begin
            ckey_ff[j] <= '0;
            ccnt_ff[j] <= '0;
         end
         mfill_ff <= '0;
         cfill_ff <= '0;
         removals_ff <= '0;
         thr_ff <= tft_pkg::THR_RESET;
      end else begin
         mkey_ff <= mkey_in;
         mcnt_ff <= mcnt_in;
         ckey_ff <= ckey_in;
         ccnt_ff <= ccnt_in;
         mfill_ff <= mfill_in;
         cfill_ff <= cfill_in;
         removals_ff <= removals_in;
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mpos_ff <= mpos_in;
      cpos_ff <= cpos_in;
      if (cmd.load) begin
         key_ff <= req_key;
      end
      if (cmd.decide) begin
         kc_ff <= kc_new;
         outcome_ff <= cmd.outcome;
      end
      if (cmd.swap) begin
         dk_ff <= mkey_ff[MAIN_DEPTH-1];
         dc_ff <= mcnt_ff[MAIN_DEPTH-1];
      end
   end

   assign outcome = outcome_ff;
   assign key_count = kc_ff;
   assign main_used = mfill_ff;
   assign candidates_used = cfill_ff;
   assign removal_total = removals_ff;

   a_main_fill_range: assert property (@(posedge clock) disable iff (reset)
      mfill_ff <= MFW'(MAIN_DEPTH))
      else $error("main table overfilled");

   a_cand_fill_range: assert property (@(posedge clock) disable iff (reset)
      cfill_ff <= CFW'(CAND_DEPTH))
      else $error("candidate list overfilled");

   a_removals_grow: assert property (@(posedge clock) disable iff (reset)
      (cmd.promote || cmd.swap) |=> (removals_ff != '0))
      else $error("promotion not counted");

endmodule
`default_nettype wire

FILE: rtl/two_tier_frequent_key_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Tracks frequent keys in a sorted main table and a sorted candidate list and returns one
// result word per key word. One key is handled at a time: a word is loaded and searched, may
// insert an entry into the candidate list, and may bubble the updated entry up its list one
// position per cycle in the bubble sequencer; the result is held until taken before the
// next key is accepted. The threshold register may be written whenever the block is idle;
// it takes effect for the next key.
module two_tier_frequent_key_tracker #(
   parameter int MAIN_DEPTH = 16,
   parameter int CAND_DEPTH = 32,
   parameter int KEY_BITS = 32
) (
   input wire logic clock,
   input wire logic reset,
   tft_req_if.sink req,
   tft_rsp_if.source rsp,
   tft_csr_if.sink csr
);

   tft_pkg::cmd_type cmd;
   tft_pkg::status_type status;

   assign csr.ready = 1'b1;

   tft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tft_datapath #(
      .MAIN_DEPTH (MAIN_DEPTH),
      .CAND_DEPTH (CAND_DEPTH),
      .KEY_BITS   (KEY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_key         (req.key),
      .csr_valid       (csr.valid),
      .csr_data        (csr.promote_threshold),
      .cmd             (cmd),
      .status          (status),
      .outcome         (rsp.outcome),
      .key_count       (rsp.key_count),
      .main_used       (rsp.main_used),
      .candidates_used (rsp.candidates_used),
      .removal_total   (rsp.removal_total)
   );

endmodule
`default_nettype wire
